>>> rtl/core/bgd_pkg.sv
// Package for the button gesture detector: gesture codes and register indexes.
package bgd_pkg;

	typedef enum logic [2:0] {
		GS_IDLE         = 3'd0,
		GS_SINGLE       = 3'd1,
		GS_DOUBLE       = 3'd2,
		GS_LONG_RELEASE = 3'd3,
		GS_LONG_HOLD    = 3'd4
	} gesture_t;

	typedef logic [2:0] cfg_index_t;

	localparam cfg_index_t CFG_IDLE_LEVEL      = 3'd0;
	localparam cfg_index_t CFG_DEBOUNCE_MS     = 3'd1;
	localparam cfg_index_t CFG_SHORT_PRESS_MS  = 3'd2;
	localparam cfg_index_t CFG_LONG_PRESS_MS   = 3'd3;
	localparam cfg_index_t CFG_MULTI_WINDOW_MS = 3'd4;

	localparam logic [15:0] DEBOUNCE_RESET     = 16'd50;
	localparam logic [15:0] SHORT_PRESS_RESET  = 16'd300;
	localparam logic [15:0] LONG_PRESS_RESET   = 16'd1000;
	localparam logic [15:0] MULTI_WINDOW_RESET = 16'd400;

	localparam logic [1:0] COUNT_MAX = 2'd3;

endpackage

>>> rtl/core/bgd_poll_if.sv
// Channel interfaces of the button gesture detector: polls, results and configuration.
interface bgd_poll_if;
	logic        valid;
	logic        ready;
	logic        raw_level;
	logic [31:0] now_ms;

	modport source (output valid, output raw_level, output now_ms, input ready);
	modport sink (input valid, input raw_level, input now_ms, output ready);
endinterface

interface bgd_result_if;
	logic             valid;
	logic             ready;
	bgd_pkg::gesture_t gesture_state;
	logic             single_event;
	logic             double_event;
	logic             long_release_event;
	logic             long_hold_event;
	logic             hold_release_event;

	modport source (output valid, output gesture_state, output single_event,
		output double_event, output long_release_event, output long_hold_event,
		output hold_release_event, input ready);
	modport sink (input valid, input gesture_state, input single_event,
		input double_event, input long_release_event, input long_hold_event,
		input hold_release_event, output ready);
endinterface

interface bgd_cfg_if;
	logic                valid;
	logic                ready;
	bgd_pkg::cfg_index_t index;
	logic [15:0]         data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/core/button_gesture_detector.sv
// Button gesture detector: debounce, press timing and single/double/long gesture report.
// A poll passes through the input register and then the result register; a stalled
// result side holds it back. Throughput: one poll per cycle while results are taken;
// an input register and a result register part the two sides, so a poll is taken while
// a finished result still waits, as long as the input register is empty.
// Reset (arst_n low, asynchronous) clears the pipeline, restores the register
// defaults and returns the press tracking to idle with the stable level released.
module button_gesture_detector (
	input  logic               clk,
	input  logic               arst_n,
	bgd_poll_if.sink           poll,
	bgd_result_if.source       result,
	bgd_cfg_if.sink            cfg
);

	// Configuration registers.
	logic        idle_level_q;
	logic [15:0] debounce_ms_q;
	logic [15:0] short_press_ms_q;
	logic [15:0] long_press_ms_q;
	logic [15:0] multi_window_ms_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_level_q      <= 1'b1;
			debounce_ms_q     <= bgd_pkg::DEBOUNCE_RESET;
			short_press_ms_q  <= bgd_pkg::SHORT_PRESS_RESET;
			long_press_ms_q   <= bgd_pkg::LONG_PRESS_RESET;
			multi_window_ms_q <= bgd_pkg::MULTI_WINDOW_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				bgd_pkg::CFG_IDLE_LEVEL:      idle_level_q      <= cfg.data[0];
				bgd_pkg::CFG_DEBOUNCE_MS:     debounce_ms_q     <= cfg.data;
				bgd_pkg::CFG_SHORT_PRESS_MS:  short_press_ms_q  <= cfg.data;
				bgd_pkg::CFG_LONG_PRESS_MS:   long_press_ms_q   <= cfg.data;
				bgd_pkg::CFG_MULTI_WINDOW_MS: multi_window_ms_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// Input register.
	logic        valid_s1;
	logic        level_s1;
	logic [31:0] now_s1;
	logic        advance;

	logic        out_valid_q;

	assign advance    = !out_valid_q || result.ready;
	assign poll.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (poll.ready) begin
			valid_s1 <= poll.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (poll.valid && poll.ready) begin
			level_s1 <= poll.raw_level;
			now_s1   <= poll.now_ms;
		end
	end

	// Gesture tracking state.
	logic              previous_raw_q;
	logic              stable_level_q;
	logic [31:0]       last_edge_time_q;
	logic              pressed_q;
	logic              held_q;
	logic [31:0]       press_start_time_q;
	logic [1:0]        count_q;
	logic [31:0]       last_short_time_q;
	logic [31:0]       count_set_time_q;
	bgd_pkg::gesture_t reported_q;

	// Next-state values for the poll held in the input register.
	logic [31:0]       edge_time;
	logic              debounced;
	logic              press;
	logic              release_det;
	logic              pressed_n;
	logic [31:0]       press_start_n;
	logic [31:0]       duration;
	logic              short_press;
	logic              in_window;
	logic [1:0]        count_a;
	logic [1:0]        count_n;
	logic [31:0]       short_time_n;
	logic              hold_fire;
	logic              held_a;
	logic              held_n;
	logic              hold_rel;
	logic              expired;
	bgd_pkg::gesture_t state_a;
	bgd_pkg::gesture_t state_b;
	bgd_pkg::gesture_t state_n;
	logic              ev_single;
	logic              ev_double;
	logic              ev_lrel;

	always_comb begin
		edge_time   = (level_s1 != previous_raw_q) ? now_s1 : last_edge_time_q;
		debounced   = ((now_s1 - edge_time) > {16'd0, debounce_ms_q})
			&& (level_s1 != stable_level_q);
		press       = debounced && (level_s1 != idle_level_q) && !pressed_q;
		release_det = debounced && (level_s1 == idle_level_q) && pressed_q;
		pressed_n   = press ? 1'b1 : (release_det ? 1'b0 : pressed_q);
		press_start_n = press ? now_s1 : press_start_time_q;

		duration    = now_s1 - press_start_time_q;
		short_press = release_det && (duration < {16'd0, short_press_ms_q});
		in_window   = (now_s1 - last_short_time_q) < {16'd0, multi_window_ms_q};

		count_a = count_q;
		if (short_press) begin
			if (!in_window) begin
				count_a = 2'd1;
			end else if (count_q != bgd_pkg::COUNT_MAX) begin
				count_a = count_q + 2'd1;
			end
		end
		short_time_n = short_press ? now_s1 : last_short_time_q;

		state_a   = press ? bgd_pkg::GS_IDLE : reported_q;
		ev_single = 1'b0;
		ev_double = 1'b0;
		ev_lrel   = 1'b0;
		if (short_press) begin
			if (count_a == 2'd2) begin
				state_a   = bgd_pkg::GS_DOUBLE;
				ev_double = 1'b1;
			end else if (count_a == bgd_pkg::COUNT_MAX) begin
				// A third or later quick press is reported as a single at once.
				state_a   = bgd_pkg::GS_SINGLE;
				ev_single = 1'b1;
			end
		end else if (release_det && (duration < {16'd0, long_press_ms_q})) begin
			state_a = bgd_pkg::GS_LONG_RELEASE;
			ev_lrel = 1'b1;
		end

		hold_fire = pressed_n && ((now_s1 - press_start_n) > {16'd0, long_press_ms_q})
			&& (state_a != bgd_pkg::GS_LONG_HOLD);
		held_a  = hold_fire || held_q;
		state_b = hold_fire ? bgd_pkg::GS_LONG_HOLD : state_a;

		hold_rel = !pressed_n && held_a;
		held_n   = held_a && !hold_rel;
		if (hold_rel) begin
			state_b = bgd_pkg::GS_IDLE;
		end

		// Once the window has run out, a lone short press is reported as single.
		// A short press in this poll restarts the window, so it cannot expire here.
		expired = !short_press
			&& ((now_s1 - count_set_time_q) > {16'd0, multi_window_ms_q});
		state_n = state_b;
		count_n = count_a;
		if (expired) begin
			if (count_a == 2'd1) begin
				state_n   = bgd_pkg::GS_SINGLE;
				ev_single = 1'b1;
			end
			count_n = 2'd0;
		end
	end

	logic step;
	assign step = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			previous_raw_q     <= 1'b1;
			stable_level_q     <= 1'b1;
			last_edge_time_q   <= '0;
			pressed_q          <= 1'b0;
			held_q             <= 1'b0;
			press_start_time_q <= '0;
			count_q            <= '0;
			last_short_time_q  <= '0;
			count_set_time_q   <= '0;
			reported_q         <= bgd_pkg::GS_IDLE;
		end else if (step) begin
			previous_raw_q     <= level_s1;
			stable_level_q     <= debounced ? level_s1 : stable_level_q;
			last_edge_time_q   <= edge_time;
			pressed_q          <= pressed_n;
			held_q             <= held_n;
			press_start_time_q <= press_start_n;
			count_q            <= count_n;
			last_short_time_q  <= short_time_n;
			count_set_time_q   <= short_time_n;
			reported_q         <= state_n;
		end
	end

	// Result register.
	bgd_pkg::gesture_t gesture_q;
	logic              single_q;
	logic              double_q;
	logic              lrel_q;
	logic              hold_q;
	logic              hrel_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			gesture_q <= state_n;
			single_q  <= ev_single;
			double_q  <= ev_double;
			lrel_q    <= ev_lrel;
			hold_q    <= hold_fire;
			hrel_q    <= hold_rel;
		end
	end

	assign result.valid              = out_valid_q;
	assign result.gesture_state      = gesture_q;
	assign result.single_event       = single_q;
	assign result.double_event       = double_q;
	assign result.long_release_event = lrel_q;
	assign result.long_hold_event    = hold_q;
	assign result.hold_release_event = hrel_q;

	// A hold can only be flagged while the button is still down.
	a_held_implies_pressed: assert property (@(posedge clk) disable iff (!arst_n)
		held_q |-> pressed_q)
		else $error("held flag set while button is released");

	// A beat leaving the input register always lands in the result register.
	a_step_fills_output: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> out_valid_q)
		else $error("result register empty after a step");

	// Single and double are never reported for the same poll.
	a_single_double_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(single_q && double_q))
		else $error("single and double raised together");

endmodule

>>> tb/button_gesture_detector_tb.sv
// Testbench for the button gesture detector: poll stimulus, gesture prediction and result checks.
module button_gesture_detector_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 2000;

	typedef struct packed {
		bgd_pkg::gesture_t gesture;
		logic              single;
		logic              dbl;
		logic              lrel;
		logic              hold;
		logic              hrel;
	} gesture_report_t;

	logic clk;
	logic arst_n;

	bgd_poll_if   poll ();
	bgd_result_if result ();
	bgd_cfg_if    cfg ();

	button_gesture_detector i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.poll   (poll),
		.result (result),
		.cfg    (cfg)
	);

	// Register copies kept by the predictor.
	logic        r_idle;
	logic [15:0] r_debounce;
	logic [15:0] r_short;
	logic [15:0] r_long;
	logic [15:0] r_window;

	// Press tracking state of the predictor.
	logic              trk_prev_raw;
	logic              trk_stable;
	logic [31:0]       trk_edge_t;
	logic              trk_pressed;
	logic              trk_held;
	logic [31:0]       trk_press_t;
	logic [1:0]        trk_count;
	logic [31:0]       trk_short_t;
	logic [31:0]       trk_count_t;
	bgd_pkg::gesture_t trk_gesture;

	gesture_report_t pending_reports [$];
	gesture_report_t got_report;
	gesture_report_t want_report;
	int              mismatches = 0;

	logic [31:0] poll_time = '0;
	int unsigned polls_sent = 0;
	int unsigned burst_left = 0;
	int unsigned gap_cycles = 0;
	logic [9:0]  rx_cycle = '0;
	int unsigned idle_cycles;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic void clear_press_tracker();
		r_idle       = 1'b1;
		r_debounce   = bgd_pkg::DEBOUNCE_RESET;
		r_short      = bgd_pkg::SHORT_PRESS_RESET;
		r_long       = bgd_pkg::LONG_PRESS_RESET;
		r_window     = bgd_pkg::MULTI_WINDOW_RESET;
		trk_prev_raw = 1'b1;
		trk_stable   = 1'b1;
		trk_edge_t   = '0;
		trk_pressed  = 1'b0;
		trk_held     = 1'b0;
		trk_press_t  = '0;
		trk_count    = '0;
		trk_short_t  = '0;
		trk_count_t  = '0;
		trk_gesture  = bgd_pkg::GS_IDLE;
	endfunction

	function automatic void apply_register(input bgd_pkg::cfg_index_t idx,
		input logic [15:0] data);
		case (idx)
			bgd_pkg::CFG_IDLE_LEVEL:      r_idle     = data[0];
			bgd_pkg::CFG_DEBOUNCE_MS:     r_debounce = data;
			bgd_pkg::CFG_SHORT_PRESS_MS:  r_short    = data;
			bgd_pkg::CFG_LONG_PRESS_MS:   r_long     = data;
			bgd_pkg::CFG_MULTI_WINDOW_MS: r_window   = data;
			default: ;
		endcase
	endfunction

	function automatic gesture_report_t predict_gesture(input logic lvl, input logic [31:0] t);
		gesture_report_t rep;
		logic [31:0]     dur;
		rep = '0;
		if (lvl != trk_prev_raw)
			trk_edge_t = t;
		if ((t - trk_edge_t) > {16'd0, r_debounce} && lvl != trk_stable) begin
			trk_stable = lvl;
			if (trk_stable != r_idle && !trk_pressed) begin
				trk_pressed = 1'b1;
				trk_press_t = t;
				trk_gesture = bgd_pkg::GS_IDLE;
			end else if (trk_stable == r_idle && trk_pressed) begin
				dur = t - trk_press_t;
				trk_pressed = 1'b0;
				if (dur < {16'd0, r_short}) begin
					// Short presses inside the window join up; the count saturates.
					if ((t - trk_short_t) < {16'd0, r_window}) begin
						if (trk_count < bgd_pkg::COUNT_MAX)
							trk_count = trk_count + 2'd1;
					end else begin
						trk_count = 2'd1;
					end
					trk_short_t = t;
					trk_count_t = t;
					if (trk_count == 2'd2) begin
						trk_gesture = bgd_pkg::GS_DOUBLE;
						rep.dbl = 1'b1;
					end else if (trk_count > 2'd2) begin
						trk_gesture = bgd_pkg::GS_SINGLE;
						rep.single = 1'b1;
					end
				end else if (dur < {16'd0, r_long}) begin
					trk_gesture = bgd_pkg::GS_LONG_RELEASE;
					rep.lrel = 1'b1;
				end
			end
		end
		if (trk_pressed && (t - trk_press_t) > {16'd0, r_long}
			&& trk_gesture != bgd_pkg::GS_LONG_HOLD) begin
			trk_gesture = bgd_pkg::GS_LONG_HOLD;
			trk_held = 1'b1;
			rep.hold = 1'b1;
		end
		if (!trk_pressed && trk_held) begin
			trk_held = 1'b0;
			trk_gesture = bgd_pkg::GS_IDLE;
			rep.hrel = 1'b1;
		end
		if ((t - trk_count_t) > {16'd0, r_window}) begin
			if (trk_count == 2'd1) begin
				trk_gesture = bgd_pkg::GS_SINGLE;
				rep.single = 1'b1;
			end
			trk_count = '0;
		end
		trk_prev_raw = lvl;
		rep.gesture = trk_gesture;
		return rep;
	endfunction

	// Register writes, poll predictions and result checks all happen here, in beat order.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg.valid && cfg.ready)
				apply_register(cfg.index, cfg.data);
			if (poll.valid && poll.ready)
				pending_reports.push_back(predict_gesture(poll.raw_level, poll.now_ms));
			if (result.valid && result.ready) begin
				got_report.gesture = result.gesture_state;
				got_report.single  = result.single_event;
				got_report.dbl     = result.double_event;
				got_report.lrel    = result.long_release_event;
				got_report.hold    = result.long_hold_event;
				got_report.hrel    = result.hold_release_event;
				if (pending_reports.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result beat: state %0d flags %b",
							got_report.gesture, got_report[4:0]);
				end else begin
					want_report = pending_reports.pop_front();
					if (got_report.gesture !== want_report.gesture ||
						got_report.single !== want_report.single ||
						got_report.dbl !== want_report.dbl ||
						got_report.lrel !== want_report.lrel ||
						got_report.hold !== want_report.hold ||
						got_report.hrel !== want_report.hrel) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"result mismatch: expected state %0d s%b d%b lr%b lh%b hr%b,",
								" got state %0d s%b d%b lr%b lh%b hr%b"},
								want_report.gesture, want_report.single, want_report.dbl,
								want_report.lrel, want_report.hold, want_report.hrel,
								got_report.gesture, got_report.single, got_report.dbl,
								got_report.lrel, got_report.hold, got_report.hrel);
					end
				end
			end
		end
	end

	// The result side stalls on a pattern chosen by the top bits of the rx_cycle counter.
	always @(posedge clk) begin
		rx_cycle <= rx_cycle + 10'd1;
		case (rx_cycle[9:8])
			2'd0: result.ready <= 1'b1;
			2'd1: result.ready <= ($urandom_range(0, 3) != 0);
			2'd2: result.ready <= (rx_cycle[4:0] < 5'd20);
			default: result.ready <= ($urandom_range(0, 1) == 1);
		endcase
	end

	initial begin
		idle_cycles = 0;
		do begin
			@(posedge clk);
			if ((poll.valid && poll.ready) || (result.valid && result.ready) ||
				(cfg.valid && cfg.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end while (idle_cycles < WATCHDOG_LIMIT);
		$display("button_gesture_detector_tb failed");
		$finish;
	end

	task automatic send_poll(input logic lvl, input logic [31:0] delta);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 48);
			gap_cycles = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap_cycles != 0) begin
				poll.valid <= 1'b0;
				repeat (gap_cycles) @(posedge clk);
			end
		end
		burst_left--;
		poll_time += delta;
		poll.valid     <= 1'b1;
		poll.raw_level <= lvl;
		poll.now_ms    <= poll_time;
		polls_sent++;
		do @(posedge clk); while (!poll.ready);
	endtask

	task automatic wait_all_reported();
		poll.valid <= 1'b0;
		do @(posedge clk); while (pending_reports.size() != 0);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_reg(input bgd_pkg::cfg_index_t idx, input logic [15:0] data);
		wait_all_reported();
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= data;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
	endtask

	task automatic set_thresholds(input logic idle, input logic [15:0] deb, input logic [15:0] sh,
		input logic [15:0] lg, input logic [15:0] win);
		write_reg(bgd_pkg::CFG_IDLE_LEVEL, {15'd0, idle});
		write_reg(bgd_pkg::CFG_DEBOUNCE_MS, deb);
		write_reg(bgd_pkg::CFG_SHORT_PRESS_MS, sh);
		write_reg(bgd_pkg::CFG_LONG_PRESS_MS, lg);
		write_reg(bgd_pkg::CFG_MULTI_WINDOW_MS, win);
	endtask

	// Holds one level for a little over span ms, polled at random intervals.
	task automatic hold_level(input logic lvl, input int unsigned span);
		int unsigned step_max;
		int unsigned elapsed;
		int unsigned step;
		step_max = span / $urandom_range(3, 8) + 1;
		send_poll(lvl, $urandom_range(0, step_max));
		elapsed = 0;
		while (elapsed <= span) begin
			step = $urandom_range(1, step_max);
			elapsed += step;
			send_poll(lvl, step);
		end
	endtask

	function automatic int unsigned around(input int unsigned centre);
		return ((centre > 30) ? centre - 30 : 0) + $urandom_range(0, 60);
	endfunction

	function automatic int unsigned press_span();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return $urandom_range(0, r_short);
			4: return around(r_short);
			5, 6: return $urandom_range(r_short, r_long);
			7: return around(r_long);
			default: return r_long + $urandom_range(1, r_long + 200);
		endcase
	endfunction

	function automatic int unsigned pause_span();
		case ($urandom_range(0, 5))
			0, 1, 2: return $urandom_range(0, r_window / 2);
			3: return around(r_window);
			4: return $urandom_range(0, r_window);
			default: return r_window + $urandom_range(1, r_window + 200);
		endcase
	endfunction

	function automatic logic [31:0] noise_step();
		case ($urandom_range(0, 3))
			0: return 32'd0;
			1: return $urandom_range(1, 100);
			2: return $urandom();
			default: return $urandom_range(0, 2 * r_long + 10);
		endcase
	endfunction

	// Mostly whole presses with random timing, with some glitches and raw noise mixed in.
	task automatic run_random_polls(input int unsigned n);
		int unsigned stop_at;
		stop_at = polls_sent + n;
		if ($urandom_range(0, 3) == 0)
			poll_time = 32'hFFFF_FFFF - $urandom_range(0, 300000);
		else
			poll_time = $urandom();
		while (polls_sent < stop_at) begin
			case ($urandom_range(0, 9))
				0: begin
					send_poll(~r_idle, $urandom_range(0, r_debounce));
					send_poll(r_idle, $urandom_range(0, r_debounce));
				end
				1: repeat ($urandom_range(1, 6))
					send_poll($urandom_range(0, 1) == 1, noise_step());
				default: begin
					hold_level(~r_idle, r_debounce + press_span());
					hold_level(r_idle, r_debounce + pause_span());
				end
			endcase
		end
	endtask

	// Runs on the reset settings: debounce 50, short 300, long 1000, window 400.
	task automatic test_directed_gestures();
		poll_time = '0;
		// Lone short press, reported once the window runs out.
		send_poll(1'b0, 10);
		send_poll(1'b0, 51);
		send_poll(1'b1, 100);
		send_poll(1'b1, 51);
		send_poll(1'b1, 401);
		// Double press, then a third quick press that reports single at once.
		send_poll(1'b0, 10);
		send_poll(1'b0, 51);
		send_poll(1'b1, 50);
		send_poll(1'b1, 51);
		send_poll(1'b0, 10);
		send_poll(1'b0, 51);
		send_poll(1'b1, 10);
		send_poll(1'b1, 51);
		send_poll(1'b0, 10);
		send_poll(1'b0, 51);
		send_poll(1'b1, 10);
		send_poll(1'b1, 51);
		// Medium press; the saturated count clears silently on the way.
		send_poll(1'b0, 10);
		send_poll(1'b0, 51);
		send_poll(1'b1, 500);
		send_poll(1'b1, 51);
		// Short press, then a hold whose threshold poll also expires the window.
		send_poll(1'b0, 10);
		send_poll(1'b0, 51);
		send_poll(1'b1, 10);
		send_poll(1'b1, 51);
		send_poll(1'b0, 10);
		send_poll(1'b0, 51);
		send_poll(1'b0, 1001);
		send_poll(1'b1, 10);
		send_poll(1'b1, 51);
	endtask

	task automatic test_idle_level_rewrite();
		// Flip the idle level while the button is held, and back again later.
		hold_level(1'b0, r_debounce + 20);
		write_reg(bgd_pkg::CFG_IDLE_LEVEL, 16'd0);
		hold_level(1'b0, 30);
		hold_level(1'b1, r_debounce + 20);
		hold_level(1'b0, r_debounce + 20);
		write_reg(bgd_pkg::CFG_IDLE_LEVEL, 16'd0);
		hold_level(1'b1, r_debounce + 20);
		hold_level(1'b0, r_debounce + 20);
		write_reg(bgd_pkg::CFG_IDLE_LEVEL, 16'd1);
		hold_level(1'b1, r_debounce + 20);
		hold_level(1'b0, r_debounce + 20);
		hold_level(1'b1, r_debounce + 20);
	endtask

	task automatic test_reset_settings();
		set_thresholds(1'b1, bgd_pkg::DEBOUNCE_RESET, bgd_pkg::SHORT_PRESS_RESET,
			bgd_pkg::LONG_PRESS_RESET, bgd_pkg::MULTI_WINDOW_RESET);
		run_random_polls(300);
	endtask

	task automatic test_debounce_zero();
		set_thresholds(1'b0, 16'd0, 16'd300, 16'd1000, 16'd400);
		run_random_polls(250);
	endtask

	task automatic test_all_zero_thresholds();
		set_thresholds(1'b1, 16'd0, 16'd0, 16'd0, 16'd0);
		run_random_polls(250);
	endtask

	task automatic test_max_thresholds();
		set_thresholds(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		run_random_polls(250);
	endtask

	task automatic test_random_settings();
		set_thresholds($urandom_range(0, 1) == 1, 16'($urandom_range(0, 120)),
			16'($urandom_range(50, 600)), 16'($urandom_range(200, 2000)),
			16'($urandom_range(50, 800)));
		run_random_polls(250);
		set_thresholds($urandom_range(0, 1) == 1, 16'($urandom_range(0, 65535)),
			16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
			16'($urandom_range(0, 65535)));
		run_random_polls(250);
		// Short threshold above the long one.
		set_thresholds($urandom_range(0, 1) == 1, 16'($urandom_range(0, 60)), 16'd1500,
			16'd500, 16'd2000);
		run_random_polls(250);
	endtask

	initial begin
		arst_n         <= 1'b0;
		poll.valid     <= 1'b0;
		poll.raw_level <= 1'b1;
		poll.now_ms    <= '0;
		cfg.valid      <= 1'b0;
		cfg.index      <= bgd_pkg::CFG_IDLE_LEVEL;
		cfg.data       <= '0;
		clear_press_tracker();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_gestures();
		test_idle_level_rewrite();
		test_reset_settings();
		test_debounce_zero();
		test_all_zero_thresholds();
		test_max_thresholds();
		test_random_settings();

		wait_all_reported();
		repeat (4) @(posedge clk);
		if (mismatches == 0 && pending_reports.size() == 0)
			$display("button_gesture_detector_tb passed");
		else
			$display("button_gesture_detector_tb failed");
		$finish;
	end

endmodule

>>> sim.f
rtl/core/bgd_pkg.sv
rtl/core/bgd_poll_if.sv
rtl/core/button_gesture_detector.sv
tb/button_gesture_detector_tb.sv
